>>> rtl/core/lru_key_value_cache_top_macros.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared clocked assertion forms, disabled during reset
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// same-cycle implication
`define LRUC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LRUC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lru key-value cache package
// transaction types, field widths and fixed codes
// ----------------------------------------------------------------------------
package lruc_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;

   localparam logic [CAP_BITS-1:0]   CAP_RESET  = 5'd16;
   localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [KEY_BITS-1:0]    key;
      logic signed [VALUE_BITS-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic signed [VALUE_BITS-1:0]  read_value;
   } rsp_type;

endpackage

>>> rtl/core/lruc_lookup.sv
// ----------------------------------------------------------------------------
// lru key-value cache lookup
// parallel key match over all entries, lowest matching entry wins
// ----------------------------------------------------------------------------
module lruc_lookup #(
   parameter int ENTRIES = 16
) (
   input  logic [ENTRIES-1:0]              valid,
   input  logic [lruc_pkg::KEY_BITS-1:0]   keys [ENTRIES],
   input  logic [lruc_pkg::KEY_BITS-1:0]   probe,
   output logic [ENTRIES-1:0]              hit_vec,
   output logic                            hit
);

   logic [ENTRIES-1:0] match;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid[i] && (keys[i] == probe);
      end
   end

   // isolate lowest set bit
   assign hit_vec = match & (~match + ENTRIES'(1));
   assign hit     = |match;

endmodule

>>> rtl/core/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru key-value cache
// fully associative key-value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage
//   req channel: a transaction (get or put) is taken at a rising edge with
//   start high and busy low; busy stays low, so one transaction per cycle
//   rsp channel: one result per transaction, shown for exactly one cycle
//   with rsp_valid high; the receiver has no way to stall it
//   csr channel: capacity write, taken when csr_valid and csr_ready are high;
//   csr_ready is always high, write only while no transaction is in flight
// path: the request lands in an input register; the whole lookup and state
//   update run from it and load the result register, which drives rsp_valid
//   and rsp_data
// throughput: one transaction per cycle, set by the combinational parallel
//   key match and rank update between the input and result registers
// reset: synchronous, active high; store empty, capacity 16, nothing in flight
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_top_macros.svh"

module lru_key_value_cache_top #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lruc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output lruc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lruc_pkg::CAP_BITS-1:0]       csr_data
);

   localparam int RANK_BITS = $clog2(ENTRIES);
   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (FILL_BITS > lruc_pkg::CAP_BITS) ? FILL_BITS
                                                                : lruc_pkg::CAP_BITS;

   // configuration
   logic [lruc_pkg::CAP_BITS-1:0]   cap_ff;

   // input register
   logic                            req_vld_ff;
   lruc_pkg::req_type               req_ff;

   // result register
   logic                            rsp_vld_ff, rsp_vld_in;
   lruc_pkg::rsp_type               rsp_ff, rsp_in;

   // entry state
   logic [lruc_pkg::KEY_BITS-1:0]   key_ff [ENTRIES];
   logic [lruc_pkg::KEY_BITS-1:0]   key_in [ENTRIES];
   logic [lruc_pkg::VALUE_BITS-1:0] val_ff [ENTRIES];
   logic [lruc_pkg::VALUE_BITS-1:0] val_in [ENTRIES];
   logic [RANK_BITS-1:0]            rank_ff [ENTRIES];
   logic [RANK_BITS-1:0]            rank_in [ENTRIES];
   logic [ENTRIES-1:0]              valid_ff, valid_in;
   logic [FILL_BITS-1:0]            fill_ff, fill_in;

   // working signals
   logic [ENTRIES-1:0]              hit_vec;
   logic                            hit;
   logic [RANK_BITS-1:0]            hit_rank;
   logic [lruc_pkg::VALUE_BITS-1:0] hit_val;
   logic [CMP_BITS-1:0]             cap_ext, cap_eff;
   logic [FILL_BITS-1:0]            fill_m1;
   logic [RANK_BITS-1:0]            old_rank;
   logic [ENTRIES-1:0]              victim_vec, free_vec, slot_vec, keep_vec, mru_vec;
   logic                            is_put, evict;
   logic [FILL_BITS-1:0]            valid_cnt;

   // every cycle takes a transaction, capacity writes always land
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   lruc_lookup #(
      .ENTRIES (ENTRIES)
   ) u_lookup (
      .valid   (valid_ff),
      .keys    (key_ff),
      .probe   (req_ff.key),
      .hit_vec (hit_vec),
      .hit     (hit)
   );

   // capacity clamp: zero acts as one, anything above the store acts as full size
   always_comb begin
      cap_ext = CMP_BITS'(cap_ff);
      priority if (cap_ext == '0) begin
         cap_eff = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
         cap_eff = CMP_BITS'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // least recent entry holds the rank fill-1, ranks of valid entries are distinct
   assign fill_m1  = fill_ff - FILL_BITS'(1);
   assign old_rank = fill_m1[RANK_BITS-1:0];
   assign is_put   = (req_ff.kind == lruc_pkg::KIND_PUT);
   assign evict    = is_put && !hit && (CMP_BITS'(fill_ff) >= cap_eff);

   always_comb begin
      hit_rank = '0;
      hit_val  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_rank      = hit_rank | (rank_ff[i] & {RANK_BITS{hit_vec[i]}});
         hit_val       = hit_val | (val_ff[i] & {lruc_pkg::VALUE_BITS{hit_vec[i]}});
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == old_rank);
         mru_vec[i]    = valid_ff[i] && (rank_ff[i] == '0);
      end
   end

   // insert goes to the lowest free entry, counting the evicted one as free
   assign keep_vec = valid_ff & ~(evict ? victim_vec : '0);
   assign free_vec = ~keep_vec;
   assign slot_vec = free_vec & (~free_vec + ENTRIES'(1));

   // state update and result
   always_comb begin
      valid_in   = valid_ff;
      fill_in    = fill_ff;
      rsp_vld_in = req_vld_ff;
      rsp_in     = rsp_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         val_in[i]  = val_ff[i];
         rank_in[i] = rank_ff[i];
      end

      if (req_vld_ff) begin
         rsp_in.found = hit;
         unique case (req_ff.kind)
            lruc_pkg::KIND_GET: begin
               rsp_in.read_value = hit ? hit_val : lruc_pkg::MISS_VALUE;
            end
            lruc_pkg::KIND_PUT: begin
               rsp_in.read_value = '0;
            end
            default: begin
               rsp_in.read_value = '0;
            end
         endcase

         if (hit) begin
            // touch: newer entries age by one, the hit entry becomes newest
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_BITS'(1);
               end
               if (hit_vec[i]) begin
                  rank_in[i] = '0;
                  if (is_put) begin
                     val_in[i] = req_ff.value;
                  end
               end
            end
         end else if (is_put) begin
            // insert: every surviving entry ages, the new pair is newest
            for (int i = 0; i < ENTRIES; i++) begin
               if (keep_vec[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_BITS'(1);
               end
               valid_in[i] = keep_vec[i] | slot_vec[i];
               if (slot_vec[i]) begin
                  key_in[i]  = req_ff.key;
                  val_in[i]  = req_ff.value;
                  rank_in[i] = '0;
               end
            end
            fill_in = evict ? fill_ff : fill_ff + FILL_BITS'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= lruc_pkg::CAP_RESET;
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         fill_ff    <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         req_vld_ff <= start && !busy;
         rsp_vld_ff <= rsp_vld_in;
         valid_ff   <= valid_in;
         fill_ff    <= fill_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
         val_ff[i] <= val_in[i];
      end
   end

   // number of valid entries, compared against the fill count
   assign valid_cnt = FILL_BITS'($countones(valid_ff));

   // fill count tracks the number of valid entries
   `LRUC_ASSERT_IMPL(a_fill_matches_valid, 1'b1, (valid_cnt == fill_ff), "fill count off")

   // every accepted transaction yields a result on the following cycle
   `LRUC_ASSERT_NEXT(a_rsp_follows_req, req_vld_ff, rsp_valid, "result missing after transaction")

   // a non-empty store has exactly one most recent entry
   `LRUC_ASSERT_IMPL(a_single_mru, (valid_ff != '0), $onehot(mru_vec), "mru not unique")

endmodule
